### rtl/kds_pkg.sv
// Shared types, constants and tables of the kick drum sweep voice.
`default_nettype none
package kds_pkg;

	localparam int SAMPLE_RATE      = 48000;
	localparam int SINE_TABLE_BITS  = 10;
	localparam int CURVE_TABLE_BITS = 10;

	// Serial multiplier: 32 by 32 bits, one multiplier bit per cycle.
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	// Serial divider: one quotient bit per cycle, numerator fed MSB first.
	localparam int STEP_DIV = 16 * SAMPLE_RATE;
	localparam int DIV_W    = ($clog2(STEP_DIV + 1) > 18) ? $clog2(STEP_DIV + 1) : 18;
	localparam int NUM_W    = 51;
	localparam int QUO_W    = 32;
	localparam int CNT_W    = 6;
	localparam int CK_W     = $clog2(CURVE_TABLE_BITS);

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_START_FREQ   = 3'd0;
	localparam logic [2:0] REG_MID_FREQ     = 3'd1;
	localparam logic [2:0] REG_END_FREQ     = 3'd2;
	localparam logic [2:0] REG_FIRST_TIME   = 3'd3;
	localparam logic [2:0] REG_SECOND_TIME  = 3'd4;
	localparam logic [2:0] REG_FIRST_CURVE  = 3'd5;
	localparam logic [2:0] REG_SECOND_CURVE = 3'd6;
	localparam logic [2:0] REG_END_LEVEL    = 3'd7;

	// MIDI status codes.
	localparam logic [7:0] MIDI_KIND_MASK = 8'hF0;
	localparam logic [7:0] MIDI_NOTE_ON   = 8'h90;
	localparam logic [7:0] MIDI_NOTE_OFF  = 8'h80;

	// Fixed-point constants.
	localparam logic [31:0] Q30         = 32'd1073741824;
	localparam logic [23:0] ONE23       = 24'd8388608;
	localparam logic [23:0] MAX23       = 24'd8388607;
	localparam logic [31:0] CURVE_SCALE = 32'd58982;
	localparam logic [31:0] GAIN_KEEP   = 32'd8346665;
	localparam logic [31:0] GAIN_PULL   = 32'd41943;
	localparam logic [31:0] ENV_ATK     = 32'd8380219;
	localparam logic [31:0] ENV_REL     = 32'd8371831;
	localparam logic [63:0] ROUND23     = 64'd4194304;
	localparam logic [63:0] ENV_ATK_ADD = 64'd70376226816;
	localparam logic [23:0] ENV_FLOOR   = 24'd839;
	localparam logic [31:0] SIN_C0      = 32'd5026990;
	localparam logic [30:0] SIN_C1      = 31'd85569306;
	localparam logic [30:0] SIN_C2      = 31'd693598669;
	localparam logic [30:0] SIN_C3      = 31'd1686629713;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_ECRV, ST_PDIV, ST_NORM, ST_SQR, ST_NEGM, ST_EXPL,
		ST_RSH, ST_FMUL, ST_GAIN1, ST_GAIN2, ST_ENV, ST_STEP, ST_Z2, ST_P1,
		ST_P2, ST_P3, ST_P4, ST_OG, ST_OE, ST_FIN
	} state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] midi_status;
		logic [6:0] midi_velocity;
	} din_t;

	typedef struct packed {
		logic signed [23:0] sample_out;
	} dout_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [18:0] value;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] den;
		logic [CNT_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	// 2^(-2^-k) in Q0.30 for k = 1 upward, indexed from zero.
	function automatic logic [29:0] exp_tab(input logic [3:0] k);
		logic [29:0] v;
		case (k)
			4'd0:    v = 30'd759250125;
			4'd1:    v = 30'd902905650;
			4'd2:    v = 30'd984625594;
			4'd3:    v = 30'd1028218694;
			4'd4:    v = 30'd1050733751;
			4'd5:    v = 30'd1062175492;
			4'd6:    v = 30'd1067942999;
			4'd7:    v = 30'd1070838487;
			4'd8:    v = 30'd1072289173;
			4'd9:    v = 30'd1073015252;
			4'd10:   v = 30'd1073378476;
			4'd11:   v = 30'd1073560134;
			4'd12:   v = 30'd1073650976;
			4'd13:   v = 30'd1073696399;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### rtl/kds_if.sv
// Valid/ready channel interfaces of the kick drum sweep voice.
`default_nettype none
interface kds_din_if;
	logic          valid;
	logic          ready;
	kds_pkg::din_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kds_dout_if;
	logic           valid;
	logic           ready;
	kds_pkg::dout_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kds_cfg_if;
	logic          valid;
	logic          ready;
	kds_pkg::cfg_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/kick_drum_sweep_voice.sv
// Top level of the kick drum voice: sequencer, voice state and configuration.
`default_nettype none
// A MIDI transaction on din acts at once and gives no sample: a note-on
// with nonzero velocity restarts the sweep and the phase and opens the gate, a
// note-off or a zero-velocity note-on closes it. A tick transaction yields one
// sample on dout. A tick is worked out by a sequencer around one bit-serial
// 32 by 32 multiplier and one bit-serial divider (one quotient bit per cycle).
// After the sweep a tick takes 10 products and a 51-step division; during the
// sweep the curve adds up to 13 + 2*CURVE_TABLE_BITS products in all, a 34-step
// division and a leading-one search. Input is taken only while the sequencer
// is idle; a finished sample waits in the output register, and the next
// transaction is accepted while it waits. Configuration writes are always
// accepted and must be made while the voice is idle.
module kick_drum_sweep_voice (
	input  logic clk,
	input  logic arst_n,
	kds_din_if.sink    din,
	kds_dout_if.source dout,
	kds_cfg_if.sink    cfg
);
	localparam int CTB   = kds_pkg::CURVE_TABLE_BITS;
	localparam int STB   = kds_pkg::SINE_TABLE_BITS;
	localparam int NEG_W = CTB + 5;
	localparam logic [kds_pkg::CK_W-1:0] K_LAST = kds_pkg::CK_W'(CTB - 1);
	localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - STB)) - 32'd1);

	// Configuration registers.
	logic [18:0] start_freq_q, mid_freq_q, end_freq_q;
	logic [17:0] first_time_q, second_time_q;
	logic [15:0] first_curve_q, second_curve_q, end_level_q;

	// Voice state.
	logic [31:0] timer_q, phase_q;
	logic [23:0] env_q, gain_q;
	logic        gate_q;

	// Sequencer.
	kds_pkg::state_t state_q, state_d, next_st;
	logic            launched_q, launched_d, op_done, mul_use, div_use;

	// Work registers of one tick.
	logic [18:0]             a_q, b_q, freq_q;
	logic [17:0]             d_q, len_q;
	logic [15:0]             curve_q, p_q;
	logic                    insweep_q, neg_q;
	logic [4:0]              s_q, q_q;
	logic [31:0]             m_q;
	logic [CTB-1:0]          frac_q, f_q;
	logic [kds_pkg::CK_W-1:0] k_q;
	logic [16:0]             e_q, cp_q;
	logic [30:0]             r_q, z_q, z2_q, poly_q;
	logic [63:0]             acc_q;
	logic [26:0]             om_q;
	logic [23:0]             out_q;
	logic                    out_valid_q;

	kds_pkg::mul_req_t mreq;
	kds_pkg::mul_rsp_t mrsp;
	kds_pkg::div_req_t dreq;
	kds_pkg::div_rsp_t drsp;

	kds_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	kds_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic        din_fire, cfg_fire, dout_fire;
	logic [18:0] total;
	logic        in_sweep, seg1;
	logic [7:0]  midi_kind;
	logic [31:0] sq_t, new_phase, qp;
	logic [NEG_W-1:0] neg_val, y_val;
	logic [18:0] diff, dl;
	logic [63:0] gsum, esum;
	logic [23:0] env_new, mag;
	logic [30:0] z_raw, r_sh;
	logic [26:0] s_raw;

	assign din_fire  = din.valid && din.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign dout_fire = dout.valid && dout.ready;
	assign din.ready = (state_q == kds_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign dout.valid = out_valid_q;
	assign dout.data.sample_out = out_q;
	assign midi_kind = din.data.midi_status & kds_pkg::MIDI_KIND_MASK;

	// Sweep position against the two segments.
	assign total    = {1'b0, first_time_q} + {1'b0, second_time_q};
	assign in_sweep = timer_q < {13'd0, total};
	assign seg1     = timer_q < {14'd0, first_time_q};

	// Datapath arithmetic shared by the capture steps.
	assign sq_t      = mrsp.prod[61:30];
	assign neg_val   = NEG_W'({s_q + 5'd1, {CTB{1'b0}}}) - NEG_W'(frac_q);
	assign y_val     = mrsp.prod[NEG_W+15:16];
	assign r_sh      = (q_q == 5'd31) ? 31'd0 : (r_q >> q_q);
	assign diff      = (b_q >= a_q) ? (b_q - a_q) : (a_q - b_q);
	assign dl        = mrsp.prod[34:16];
	assign gsum      = acc_q + mrsp.prod + kds_pkg::ROUND23;
	assign esum      = mrsp.prod + (gate_q ? kds_pkg::ENV_ATK_ADD : kds_pkg::ROUND23);
	assign env_new   = esum[46:23];
	assign new_phase = phase_q + drsp.quo;
	// The phase is cut to the sine table resolution; odd quadrants mirror when z_q is captured.
	assign qp        = new_phase & PH_MASK;
	assign z_raw     = {1'b0, qp[29:0]};
	assign s_raw     = mrsp.prod[63:37];
	assign mag       = neg_q ? ((om_q > 27'(kds_pkg::ONE23)) ? kds_pkg::ONE23 : om_q[23:0])
	                         : ((om_q > 27'(kds_pkg::MAX23)) ? kds_pkg::MAX23 : om_q[23:0]);

	// Next state, unit requests and operand selection.
	always_comb begin
		state_d    = state_q;
		launched_d = launched_q;
		next_st    = state_q;
		op_done    = 1'b0;
		mul_use    = 1'b0;
		div_use    = 1'b0;
		mreq       = '0;
		dreq       = '0;
		case (state_q)
			kds_pkg::ST_IDLE: begin
				op_done = din_fire && !din.data.func;
				next_st = kds_pkg::ST_PREP;
			end
			kds_pkg::ST_PREP: begin
				op_done = 1'b1;
				next_st = in_sweep ? kds_pkg::ST_ECRV : kds_pkg::ST_GAIN1;
			end
			kds_pkg::ST_ECRV: begin
				mul_use = 1'b1;
				mreq.a  = 32'(curve_q);
				mreq.b  = kds_pkg::CURVE_SCALE;
				next_st = kds_pkg::ST_PDIV;
			end
			kds_pkg::ST_PDIV: begin
				div_use    = 1'b1;
				dreq.num   = kds_pkg::NUM_W'({d_q, 16'd0}) << (kds_pkg::NUM_W - 34);
				dreq.den   = kds_pkg::DIV_W'(len_q);
				dreq.iters = kds_pkg::CNT_W'(34);
				next_st    = (drsp.quo[15:0] == 16'd0) ? kds_pkg::ST_FMUL : kds_pkg::ST_NORM;
			end
			kds_pkg::ST_NORM: begin
				op_done = p_q[15];
				next_st = kds_pkg::ST_SQR;
			end
			kds_pkg::ST_SQR: begin
				mul_use = 1'b1;
				mreq.a  = m_q;
				mreq.b  = m_q;
				next_st = (k_q == K_LAST) ? kds_pkg::ST_NEGM : kds_pkg::ST_SQR;
			end
			kds_pkg::ST_NEGM: begin
				mul_use = 1'b1;
				mreq.a  = 32'(neg_val);
				mreq.b  = 32'(e_q);
				next_st = kds_pkg::ST_EXPL;
			end
			kds_pkg::ST_EXPL: begin
				// A clear fraction bit skips its table product.
				mul_use = f_q[CTB-1];
				op_done = !f_q[CTB-1];
				mreq.a  = 32'(r_q);
				mreq.b  = 32'(kds_pkg::exp_tab(4'(k_q)));
				next_st = (k_q == K_LAST) ? kds_pkg::ST_RSH : kds_pkg::ST_EXPL;
			end
			kds_pkg::ST_RSH: begin
				op_done = 1'b1;
				next_st = kds_pkg::ST_FMUL;
			end
			kds_pkg::ST_FMUL: begin
				mul_use = 1'b1;
				mreq.a  = 32'(diff);
				mreq.b  = 32'(cp_q);
				next_st = kds_pkg::ST_GAIN1;
			end
			kds_pkg::ST_GAIN1: begin
				mul_use = 1'b1;
				mreq.a  = 32'(gain_q);
				mreq.b  = kds_pkg::GAIN_KEEP;
				next_st = kds_pkg::ST_GAIN2;
			end
			kds_pkg::ST_GAIN2: begin
				mul_use = 1'b1;
				mreq.a  = insweep_q ? 32'(kds_pkg::ONE23) : 32'({end_level_q, 8'd0});
				mreq.b  = kds_pkg::GAIN_PULL;
				next_st = kds_pkg::ST_ENV;
			end
			kds_pkg::ST_ENV: begin
				mul_use = 1'b1;
				mreq.a  = 32'(env_q);
				mreq.b  = gate_q ? kds_pkg::ENV_ATK : kds_pkg::ENV_REL;
				next_st = kds_pkg::ST_STEP;
			end
			kds_pkg::ST_STEP: begin
				div_use    = 1'b1;
				dreq.num   = kds_pkg::NUM_W'({freq_q, 32'd0});
				dreq.den   = kds_pkg::DIV_W'(kds_pkg::STEP_DIV);
				dreq.iters = kds_pkg::CNT_W'(kds_pkg::NUM_W);
				next_st    = kds_pkg::ST_Z2;
			end
			kds_pkg::ST_Z2: begin
				mul_use = 1'b1;
				mreq.a  = 32'(z_q);
				mreq.b  = 32'(z_q);
				next_st = kds_pkg::ST_P1;
			end
			kds_pkg::ST_P1: begin
				mul_use = 1'b1;
				mreq.a  = 32'(z2_q);
				mreq.b  = kds_pkg::SIN_C0;
				next_st = kds_pkg::ST_P2;
			end
			kds_pkg::ST_P2: begin
				mul_use = 1'b1;
				mreq.a  = 32'(z2_q);
				mreq.b  = 32'(poly_q);
				next_st = kds_pkg::ST_P3;
			end
			kds_pkg::ST_P3: begin
				mul_use = 1'b1;
				mreq.a  = 32'(z2_q);
				mreq.b  = 32'(poly_q);
				next_st = kds_pkg::ST_P4;
			end
			kds_pkg::ST_P4: begin
				mul_use = 1'b1;
				mreq.a  = 32'(z_q);
				mreq.b  = 32'(poly_q);
				next_st = kds_pkg::ST_OG;
			end
			kds_pkg::ST_OG: begin
				mul_use = 1'b1;
				mreq.a  = 32'(om_q);
				mreq.b  = 32'(gain_q);
				next_st = kds_pkg::ST_OE;
			end
			kds_pkg::ST_OE: begin
				mul_use = 1'b1;
				mreq.a  = 32'(om_q);
				mreq.b  = 32'(env_q);
				next_st = kds_pkg::ST_FIN;
			end
			kds_pkg::ST_FIN: begin
				op_done = !out_valid_q || dout.ready;
				next_st = kds_pkg::ST_IDLE;
			end
			default: begin
				op_done = 1'b1;
				next_st = kds_pkg::ST_IDLE;
			end
		endcase

		// A unit is started on the first cycle of its step and its result is
		// taken on the cycle that it reports done.
		if (mul_use || div_use) begin
			if (!launched_q) begin
				mreq.start = mul_use;
				dreq.start = div_use;
				launched_d = 1'b1;
			end else if ((mul_use && mrsp.done) || (div_use && drsp.done)) begin
				launched_d = 1'b0;
				op_done    = 1'b1;
			end
		end
		if (op_done) begin
			state_d = next_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kds_pkg::ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			launched_q <= launched_d;
		end
	end

	// Configuration registers and voice state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_freq_q   <= 19'd2400;
			mid_freq_q     <= 19'd1600;
			end_freq_q     <= 19'd800;
			first_time_q   <= 18'd2400;
			second_time_q  <= 18'd4800;
			first_curve_q  <= 16'd0;
			second_curve_q <= 16'd0;
			end_level_q    <= 16'd16384;
			timer_q        <= 32'hFFFF_FFFF;
			phase_q        <= 32'd0;
			env_q          <= 24'd0;
			gain_q         <= 24'd0;
			gate_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg.data.index)
					kds_pkg::REG_START_FREQ:   start_freq_q   <= cfg.data.value;
					kds_pkg::REG_MID_FREQ:     mid_freq_q     <= cfg.data.value;
					kds_pkg::REG_END_FREQ:     end_freq_q     <= cfg.data.value;
					kds_pkg::REG_FIRST_TIME:   first_time_q   <= cfg.data.value[17:0];
					kds_pkg::REG_SECOND_TIME:  second_time_q  <= cfg.data.value[17:0];
					kds_pkg::REG_FIRST_CURVE:  first_curve_q  <= cfg.data.value[15:0];
					kds_pkg::REG_SECOND_CURVE: second_curve_q <= cfg.data.value[15:0];
					kds_pkg::REG_END_LEVEL:    end_level_q    <= cfg.data.value[15:0];
					default: ;
				endcase
			end
			// A new sample loaded in the same cycle keeps the register full.
			if (dout_fire && !(op_done && state_q == kds_pkg::ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			// MIDI transactions act at once and give no sample.
			if (din_fire && din.data.func) begin
				if (midi_kind == kds_pkg::MIDI_NOTE_ON && din.data.midi_velocity != 7'd0) begin
					timer_q <= 32'd0;
					phase_q <= 32'd0;
					gate_q  <= 1'b1;
				end else if (midi_kind == kds_pkg::MIDI_NOTE_OFF ||
				             midi_kind == kds_pkg::MIDI_NOTE_ON) begin
					gate_q <= 1'b0;
				end
			end
			if (op_done) begin
				case (state_q)
					kds_pkg::ST_GAIN2: gain_q <= gsum[46:23];
					kds_pkg::ST_ENV: begin
						// On release the envelope snaps to zero once it is tiny.
						env_q <= (!gate_q && env_new < kds_pkg::ENV_FLOOR) ? 24'd0 : env_new;
					end
					kds_pkg::ST_STEP: phase_q <= new_phase;
					kds_pkg::ST_FIN: begin
						out_valid_q <= 1'b1;
						if (timer_q != 32'hFFFF_FFFF) begin
							timer_q <= timer_q + 32'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Work registers of the tick in progress.
	always_ff @(posedge clk) begin
		if (op_done) begin
			case (state_q)
				kds_pkg::ST_PREP: begin
					insweep_q <= in_sweep;
					freq_q    <= end_freq_q;
					if (seg1) begin
						a_q     <= start_freq_q;
						b_q     <= mid_freq_q;
						d_q     <= timer_q[17:0];
						len_q   <= first_time_q;
						curve_q <= first_curve_q;
					end else begin
						a_q     <= mid_freq_q;
						b_q     <= end_freq_q;
						d_q     <= timer_q[17:0] - first_time_q;
						len_q   <= second_time_q;
						curve_q <= second_curve_q;
					end
				end
				kds_pkg::ST_ECRV: e_q <= 17'd65536 - {1'b0, mrsp.prod[31:16]};
				kds_pkg::ST_PDIV: begin
					p_q  <= drsp.quo[15:0];
					s_q  <= 5'd0;
					cp_q <= 17'd0;
				end
				kds_pkg::ST_NORM: begin
					m_q    <= {1'b0, p_q, 15'd0};
					frac_q <= '0;
					k_q    <= '0;
				end
				kds_pkg::ST_SQR: begin
					frac_q <= {frac_q[CTB-2:0], sq_t[31]};
					m_q    <= sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
					k_q    <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
				end
				kds_pkg::ST_NEGM: begin
					q_q <= y_val[NEG_W-1:CTB];
					f_q <= y_val[CTB-1:0];
					r_q <= kds_pkg::Q30[30:0];
					k_q <= '0;
				end
				kds_pkg::ST_EXPL: begin
					if (f_q[CTB-1]) begin
						r_q <= mrsp.prod[60:30];
					end
					f_q <= f_q << 1;
					k_q <= (k_q == K_LAST) ? '0 : k_q + 1'b1;
				end
				kds_pkg::ST_RSH: cp_q <= r_sh[30:14];
				kds_pkg::ST_FMUL: freq_q <= (b_q >= a_q) ? (a_q + dl) : (a_q - dl);
				kds_pkg::ST_GAIN1: acc_q <= mrsp.prod;
				kds_pkg::ST_STEP: begin
					z_q   <= qp[30] ? (kds_pkg::Q30[30:0] - z_raw) : z_raw;
					neg_q <= qp[31];
				end
				kds_pkg::ST_Z2: z2_q <= mrsp.prod[60:30];
				kds_pkg::ST_P1: poly_q <= kds_pkg::SIN_C1 - mrsp.prod[60:30];
				kds_pkg::ST_P2: poly_q <= kds_pkg::SIN_C2 - mrsp.prod[60:30];
				kds_pkg::ST_P3: poly_q <= kds_pkg::SIN_C3 - mrsp.prod[60:30];
				kds_pkg::ST_P4: om_q <= (s_raw > 27'(kds_pkg::MAX23)) ? 27'(kds_pkg::MAX23) : s_raw;
				kds_pkg::ST_OG: om_q <= mrsp.prod[49:23];
				kds_pkg::ST_OE: om_q <= mrsp.prod[49:23];
				kds_pkg::ST_FIN: out_q <= neg_q ? (24'd0 - mag) : mag;
				default: ;
			endcase
		end else if (state_q == kds_pkg::ST_NORM) begin
			// Leading-one search, one bit per cycle.
			p_q <= p_q << 1;
			s_q <= s_q + 5'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_mul_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> launched_q)
		else $error("multiplier result arrived with no step waiting for it");
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (launched_q && (state_q == kds_pkg::ST_PDIV || state_q == kds_pkg::ST_STEP)))
		else $error("divider result arrived outside a division step");
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.start && dreq.start))
		else $error("multiplier and divider started together");
	a_gate_from_midi: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gate_q) |-> $past(din_fire && din.data.func))
		else $error("gate opened without a MIDI transaction");
`endif
endmodule
`default_nettype wire

### rtl/kds_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module kds_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  kds_pkg::mul_req_t req,
	output kds_pkg::mul_rsp_t rsp
);
	localparam logic [kds_pkg::CNT_W-1:0] LAST = kds_pkg::CNT_W'(kds_pkg::MUL_W - 1);

	logic [kds_pkg::MUL_W-1:0] a_q, b_q, hi_q, lo_q;
	logic [kds_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q, done_q;
	logic [kds_pkg::MUL_W:0]   sum;

	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= sum[kds_pkg::MUL_W:1];
			lo_q <= {sum[0], lo_q[kds_pkg::MUL_W-1:1]};
			b_q  <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q, lo_q};
endmodule
`default_nettype wire

### rtl/kds_div.sv
// Restoring divider, one quotient bit per cycle, numerator shifted in MSB first.
`default_nettype none
module kds_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kds_pkg::div_req_t req,
	output kds_pkg::div_rsp_t rsp
);
	logic [kds_pkg::NUM_W-1:0] num_q;
	logic [kds_pkg::DIV_W-1:0] rem_q, den_q;
	logic [kds_pkg::QUO_W-1:0] quo_q;
	logic [kds_pkg::CNT_W-1:0] cnt_q, iters_q;
	logic                      busy_q, done_q;
	logic [kds_pkg::DIV_W:0]   trial, diff;
	logic                      ge;

	assign trial = {rem_q, num_q[kds_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == iters_q - 1'b1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q   <= req.num;
			den_q   <= req.den;
			iters_q <= req.iters;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[kds_pkg::DIV_W-1:0] : trial[kds_pkg::DIV_W-1:0];
			quo_q <= {quo_q[kds_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

### dv/kick_drum_sweep_voice_tb.sv
// Self-checking testbench of the kick drum sweep voice.
`timescale 1ns / 1ps
module kick_drum_sweep_voice_tb;

	// Item kinds carried in the func field.
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_MIDI = 1'b1;
	localparam longint unsigned STEP_DEN   = 64'd16 * kds_pkg::SAMPLE_RATE;
	localparam int              CTB        = kds_pkg::CURVE_TABLE_BITS;
	localparam int              STB        = kds_pkg::SINE_TABLE_BITS;
	localparam int              HOLD_LONG  = 6000;
	localparam int              IDLE_WAIT  = 20;
	localparam int              DRAIN_WAIT = 1500;

	logic clk;
	logic arst_n;

	kds_din_if  din();
	kds_dout_if dout();
	kds_cfg_if  cfg();

	kick_drum_sweep_voice u_top (
		.clk(clk),
		.arst_n(arst_n),
		.din(din),
		.dout(dout),
		.cfg(cfg)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Shadow copy of the voice: registers and running state.
	logic [31:0] reg_shadow [8];
	logic [31:0] sweep_count;
	logic [31:0] phase_acc;
	logic [23:0] env_level;
	logic [23:0] gain_level;
	logic        gate_is_open;

	logic [23:0] expected_samples [$];
	int          mismatch_count;
	int          burst_left;
	logic        hold_request;

	// Segment progress p raised to the curve exponent, all in Q0.16.
	function automatic logic [31:0] shaped_progress(input logic [31:0] p, input logic [31:0] e);
		int unsigned n;
		int unsigned k;
		logic [63:0] m, frac, nlog, y, q, f, r;
		if (p == 0)
			return 32'd0;
		n = 0;
		while (n < 15 && (p >> (n + 1)) != 0)
			n++;
		m = 64'(p) << (30 - n);
		frac = 0;
		// Repeated squaring yields the fraction bits of log2 one by one.
		for (k = 0; k < CTB; k++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 2 * 64'(kds_pkg::Q30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		nlog = (64'(16 - n) << CTB) - frac;
		y = (nlog * 64'(e)) >> 16;
		q = y >> CTB;
		f = y & ((64'd1 << CTB) - 1);
		r = 64'(kds_pkg::Q30);
		for (k = 1; k <= CTB; k++)
			if ((f >> (CTB - k)) & 1)
				r = (r * 64'(kds_pkg::exp_tab(4'(k - 1)))) >> 30;
		r = (q >= 31) ? 64'd0 : (r >> q);
		return 32'(r >> 14);
	endfunction

	function automatic logic [31:0] segment_freq(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] d, input logic [31:0] len, input logic [31:0] crv);
		logic [31:0] p, e;
		logic [63:0] cp;
		p = 32'((64'(d) << 16) / 64'(len));
		e = 32'd65536 - 32'((64'(crv) * 64'(kds_pkg::CURVE_SCALE)) >> 16);
		cp = 64'(shaped_progress(p, e));
		if (b >= a)
			return a + 32'((64'(b - a) * cp) >> 16);
		return a - 32'((64'(a - b) * cp) >> 16);
	endfunction

	// Quarter-wave polynomial sine: magnitude in Q1.23, sign in lower_half.
	function automatic logic [63:0] sine_magnitude(input logic [31:0] ph, output logic lower_half);
		logic [31:0] qp, quad;
		logic [63:0] z, z2, poly, s;
		qp = (ph >> (32 - STB)) << (32 - STB);
		quad = qp >> 30;
		z = 64'(qp & 32'h3FFF_FFFF);
		if (quad[0])
			z = 64'(kds_pkg::Q30) - z;
		z2 = (z * z) >> 30;
		poly = 64'(kds_pkg::SIN_C1) - ((z2 * 64'(kds_pkg::SIN_C0)) >> 30);
		poly = 64'(kds_pkg::SIN_C2) - ((z2 * poly) >> 30);
		poly = 64'(kds_pkg::SIN_C3) - ((z2 * poly) >> 30);
		s = ((z * poly) >> 30) >> 7;
		if (s > 64'(kds_pkg::MAX23))
			s = 64'(kds_pkg::MAX23);
		lower_half = (quad >= 2);
		return s;
	endfunction

	function automatic void shadow_reset();
		reg_shadow[kds_pkg::REG_START_FREQ]   = 2400;
		reg_shadow[kds_pkg::REG_MID_FREQ]     = 1600;
		reg_shadow[kds_pkg::REG_END_FREQ]     = 800;
		reg_shadow[kds_pkg::REG_FIRST_TIME]   = 2400;
		reg_shadow[kds_pkg::REG_SECOND_TIME]  = 4800;
		reg_shadow[kds_pkg::REG_FIRST_CURVE]  = 0;
		reg_shadow[kds_pkg::REG_SECOND_CURVE] = 0;
		reg_shadow[kds_pkg::REG_END_LEVEL]    = 16384;
		sweep_count  = 32'hFFFF_FFFF;
		phase_acc    = 0;
		env_level    = 0;
		gain_level   = 0;
		gate_is_open = 1'b0;
	endfunction

	// Advance the shadow voice by one accepted item; a tick queues its sample.
	function automatic void advance_voice(input kds_pkg::din_t it);
		logic [31:0] total, freq, step;
		logic [63:0] target, m;
		logic        in_sweep, lower_half;
		logic [7:0]  kind;
		kind = it.midi_status & kds_pkg::MIDI_KIND_MASK;
		if (it.func == FUNC_MIDI) begin
			if (kind == kds_pkg::MIDI_NOTE_ON && it.midi_velocity != 0) begin
				sweep_count  = 0;
				phase_acc    = 0;
				gate_is_open = 1'b1;
			end else if (kind == kds_pkg::MIDI_NOTE_OFF || kind == kds_pkg::MIDI_NOTE_ON) begin
				gate_is_open = 1'b0;
			end
			return;
		end
		total = reg_shadow[kds_pkg::REG_FIRST_TIME] + reg_shadow[kds_pkg::REG_SECOND_TIME];
		in_sweep = sweep_count < total;
		freq = reg_shadow[kds_pkg::REG_END_FREQ];
		if (in_sweep) begin
			if (sweep_count < reg_shadow[kds_pkg::REG_FIRST_TIME])
				freq = segment_freq(reg_shadow[kds_pkg::REG_START_FREQ],
					reg_shadow[kds_pkg::REG_MID_FREQ], sweep_count,
					reg_shadow[kds_pkg::REG_FIRST_TIME],
					reg_shadow[kds_pkg::REG_FIRST_CURVE]);
			else
				freq = segment_freq(reg_shadow[kds_pkg::REG_MID_FREQ],
					reg_shadow[kds_pkg::REG_END_FREQ],
					sweep_count - reg_shadow[kds_pkg::REG_FIRST_TIME],
					reg_shadow[kds_pkg::REG_SECOND_TIME],
					reg_shadow[kds_pkg::REG_SECOND_CURVE]);
		end
		target = in_sweep ? 64'(kds_pkg::ONE23) :
			(64'(reg_shadow[kds_pkg::REG_END_LEVEL]) << 8);
		gain_level = 24'((64'(gain_level) * 64'(kds_pkg::GAIN_KEEP)
			+ target * 64'(kds_pkg::GAIN_PULL) + kds_pkg::ROUND23) >> 23);
		if (gate_is_open) begin
			// The attack constant already carries the rounding term.
			env_level = 24'((64'(env_level) * 64'(kds_pkg::ENV_ATK)
				+ kds_pkg::ENV_ATK_ADD) >> 23);
		end else begin
			env_level = 24'((64'(env_level) * 64'(kds_pkg::ENV_REL) + kds_pkg::ROUND23) >> 23);
			if (env_level < kds_pkg::ENV_FLOOR)
				env_level = 0;
		end
		step = 32'((64'(freq) << 32) / STEP_DEN);
		phase_acc = phase_acc + step;
		m = sine_magnitude(phase_acc, lower_half);
		m = (m * 64'(gain_level)) >> 23;
		m = (m * 64'(env_level)) >> 23;
		if (lower_half) begin
			if (m > 64'(kds_pkg::ONE23))
				m = 64'(kds_pkg::ONE23);
			expected_samples.push_back(24'(64'd0 - m));
		end else begin
			if (m > 64'(kds_pkg::MAX23))
				m = 64'(kds_pkg::MAX23);
			expected_samples.push_back(24'(m));
		end
		if (sweep_count != 32'hFFFF_FFFF)
			sweep_count = sweep_count + 1;
	endfunction

	// Offer one item and wait for its transaction; the burst logic then decides
	// whether valid drops for a gap or stays high for the next item.
	task automatic send_item(input kds_pkg::din_t it);
		din.data  <= it;
		din.valid <= 1'b1;
		do
			@(posedge clk);
		while (!din.ready);
		advance_voice(it);
		if (burst_left == 0) begin
			din.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_tick();
		kds_pkg::din_t it;
		it.func          = FUNC_TICK;
		// The MIDI fields are don't-care on a tick; random junk shows that.
		it.midi_status   = 8'($urandom);
		it.midi_velocity = 7'($urandom);
		send_item(it);
	endtask

	task automatic send_midi(input logic [7:0] status, input logic [6:0] vel);
		kds_pkg::din_t it;
		it.func          = FUNC_MIDI;
		it.midi_status   = status;
		it.midi_velocity = vel;
		send_item(it);
	endtask

	// Drop valid and wait until every sample is back, plus a short settle so
	// the sequencer is idle before a register write.
	task automatic wait_idle();
		din.valid <= 1'b0;
		@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [18:0] value);
		cfg.data.index <= index;
		cfg.data.value <= value;
		cfg.valid      <= 1'b1;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (index)
			kds_pkg::REG_START_FREQ, kds_pkg::REG_MID_FREQ, kds_pkg::REG_END_FREQ:
				reg_shadow[index] = 32'(value);
			kds_pkg::REG_FIRST_TIME, kds_pkg::REG_SECOND_TIME:
				reg_shadow[index] = 32'(value[17:0]);
			default:
				reg_shadow[index] = 32'(value[15:0]);
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [18:0] f0, input logic [18:0] f1,
		input logic [18:0] f2, input logic [18:0] t0, input logic [18:0] t1,
		input logic [18:0] c0, input logic [18:0] c1, input logic [18:0] lvl);
		write_reg(kds_pkg::REG_START_FREQ, f0);
		write_reg(kds_pkg::REG_MID_FREQ, f1);
		write_reg(kds_pkg::REG_END_FREQ, f2);
		write_reg(kds_pkg::REG_FIRST_TIME, t0);
		write_reg(kds_pkg::REG_SECOND_TIME, t1);
		write_reg(kds_pkg::REG_FIRST_CURVE, c0);
		write_reg(kds_pkg::REG_SECOND_CURVE, c1);
		write_reg(kds_pkg::REG_END_LEVEL, lvl);
	endtask

	// Reset values: ticks on a closed gate, note-on and note-off in all their
	// forms, and statuses that must be ignored.
	task automatic test_reset_defaults();
		repeat (3) send_tick();
		send_midi(kds_pkg::MIDI_NOTE_ON, 7'd127);
		repeat (6) send_tick();
		send_midi(kds_pkg::MIDI_NOTE_ON | 8'h0F, 7'd0);
		repeat (3) send_tick();
		send_midi(8'hA5, 7'd64);
		send_midi(8'hF0, 7'd127);
		send_midi(kds_pkg::MIDI_NOTE_OFF | 8'h0F, 7'd127);
		repeat (3) send_tick();
		send_midi(kds_pkg::MIDI_NOTE_ON | 8'h03, 7'd1);
		repeat (3) send_tick();
		wait_idle();
	endtask

	// Register extremes: zero-length segments, full curves, frequencies past
	// the range, and an end level above one.
	task automatic test_register_extremes();
		write_all(19'd320000, 19'd0, 19'h7FFFF, 19'd0, 19'd3, 19'hFFFF, 19'hFFFF, 19'hFFFF);
		send_midi(kds_pkg::MIDI_NOTE_ON, 7'd100);
		repeat (8) send_tick();
		wait_idle();
		write_all(19'd0, 19'd320000, 19'd0, 19'd2, 19'd0, 19'd0, 19'd0, 19'd0);
		send_midi(kds_pkg::MIDI_NOTE_ON | 8'h05, 7'd127);
		repeat (5) send_tick();
		wait_idle();
		write_all(19'd320000, 19'd320000, 19'd320000, 19'h3FFFF, 19'h3FFFF,
			19'd32768, 19'd1, 19'd32768);
		send_midi(kds_pkg::MIDI_NOTE_ON, 7'd64);
		repeat (4) send_tick();
		wait_idle();
	endtask

	// Random registers per phase, then mostly note-on/tick/note-off phrases
	// with random content and some random MIDI noise.
	task automatic test_random_phrases(input int phases, input int items_per_phase);
		int count;
		int nticks;
		int off_at;
		int i;
		logic [7:0] st;
		for (int ph = 0; ph < phases; ph++) begin
			write_reg(kds_pkg::REG_START_FREQ, ($urandom_range(0, 9) == 0) ? 19'($urandom) :
				19'($urandom_range(0, 320000)));
			write_reg(kds_pkg::REG_MID_FREQ, 19'($urandom_range(0, 320000)));
			write_reg(kds_pkg::REG_END_FREQ, ($urandom_range(0, 9) == 0) ? 19'($urandom) :
				19'($urandom_range(0, 320000)));
			write_reg(kds_pkg::REG_FIRST_TIME, 19'($urandom_range(0, 40)));
			write_reg(kds_pkg::REG_SECOND_TIME, 19'($urandom_range(0, 40)));
			write_reg(kds_pkg::REG_FIRST_CURVE, 19'($urandom));
			write_reg(kds_pkg::REG_SECOND_CURVE, 19'($urandom));
			write_reg(kds_pkg::REG_END_LEVEL, ($urandom_range(0, 4) == 0) ? 19'($urandom) :
				19'($urandom_range(0, 32768)));
			count = 0;
			while (count < items_per_phase) begin
				if ($urandom_range(0, 9) < 7) begin
					send_midi(kds_pkg::MIDI_NOTE_ON | 8'($urandom_range(0, 15)),
						7'($urandom_range(1, 127)));
					nticks = $urandom_range(2, 50);
					off_at = $urandom_range(0, 1) ? $urandom_range(0, nticks) : -1;
					for (i = 0; i < nticks; i++) begin
						if (i == off_at) begin
							if ($urandom_range(0, 1))
								send_midi(kds_pkg::MIDI_NOTE_OFF | 8'($urandom_range(0, 15)),
									7'($urandom));
							else
								send_midi(kds_pkg::MIDI_NOTE_ON | 8'($urandom_range(0, 15)),
									7'd0);
							count++;
						end
						send_tick();
					end
					count += nticks + 1;
				end else begin
					st = 8'($urandom);
					send_midi(st, 7'($urandom));
					if ((st & kds_pkg::MIDI_KIND_MASK) == kds_pkg::MIDI_NOTE_ON ||
					    (st & kds_pkg::MIDI_KIND_MASK) == kds_pkg::MIDI_NOTE_OFF)
						count++;
					nticks = $urandom_range(1, 6);
					repeat (nticks) send_tick();
					count += nticks;
				end
			end
			wait_idle();
		end
	endtask

	// The receiver stalls for a long stretch while ticks keep coming, so the
	// output register fills and the block must stall its input.
	task automatic test_output_backpressure();
		hold_request <= 1'b1;
		@(posedge clk);
		hold_request <= 1'b0;
		send_midi(kds_pkg::MIDI_NOTE_ON, 7'd90);
		burst_left = 30;
		repeat (20) send_tick();
		wait_idle();
	endtask

	// Receiver: ready follows a pattern that is picked anew at regular intervals,
	// and a hold request forces a long stall counted here.
	int rx_mode;
	int rx_cycle;
	int hold_left;
	initial begin
		dout.ready = 1'b0;
		rx_mode    = 0;
		rx_cycle   = 0;
		hold_left  = 0;
	end
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle % 128 == 0)
			rx_mode <= $urandom_range(0, 3);
		if (hold_request) begin
			hold_left  <= HOLD_LONG;
			dout.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left  <= hold_left - 1;
			dout.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0, 1:    dout.ready <= 1'b1;
				2:       dout.ready <= $urandom_range(0, 1);
				default: dout.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Each sample transaction is compared with the oldest expected sample.
	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected sample %0d", $signed(dout.data.sample_out));
			end else begin
				if (dout.data.sample_out !== expected_samples[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("sample mismatch: expected %0d, got %0d",
							$signed(expected_samples[0]), $signed(dout.data.sample_out));
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	// Watchdog far above the slowest legal run.
	initial begin
		#64000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		din.valid      = 1'b0;
		din.data       = '0;
		cfg.valid      = 1'b0;
		cfg.data       = '0;
		hold_request   = 1'b0;
		mismatch_count = 0;
		burst_left     = 0;
		shadow_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_random_phrases(6, 140);

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_samples.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
